// ----- src/olse_pkg.sv -----
// Shared constants, operation and status codes, state and memory request types.
`timescale 1ns / 1ps
`default_nettype none

package olse_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_READ   = 3'd0,
        MODE_WRITE  = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_REMOVE = 3'd3,
        MODE_DUMP   = 3'd4
    } mode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_FETCH    = 9'b000000010,
        S_SEND     = 9'b000000100,
        S_EMIT     = 9'b000001000,
        S_INS_RD   = 9'b000010000,
        S_INS_WR   = 9'b000100000,
        S_REM_TAKE = 9'b001000000,
        S_REM_RD   = 9'b010000000,
        S_REM_WR   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

// ----- src/olse_ram.sv -----
// List storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module olse_ram
    import olse_pkg::*;
(
    input  wire logic              clk,
    input  wire ram_req_t          req,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/ordered_list_shift_engine.sv -----
// Ordered list engine: read, write, insert, remove and dump over a list memory with one
// write port and one registered read port. Insert and remove shift the entries from the
// index to the end of the list, and each shifted entry costs one memory read and one
// memory write. Dump reads each word from memory before it sends it.
// Reset clears the count and the control state; memory contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_shift_engine
    import olse_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic        [2:0]        mode,
    input  wire logic        [IDX_W-1:0]  index,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed      [DATA_W-1:0] data,
    output logic             [1:0]        status,
    output logic                          last
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              single_reg, single_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] rd_data;
    logic              in_list;
    logic              out_free;
    logic              send_last;
    logic [CNT_W-1:0]  ptr_m1;
    logic [CNT_W-1:0]  ptr_p1;
    logic [CNT_W-1:0]  idx_ext;

    olse_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign in_list   = {1'b0, index} < count_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign ptr_m1    = ptr_reg - CNT_W'(1);
    assign ptr_p1    = ptr_reg + CNT_W'(1);
    assign idx_ext   = {1'b0, idx_reg};
    assign send_last = single_reg || (ptr_p1 == count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        single_next     = single_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next      = index;
                    val_next      = value;
                    res_data_next = '0;
                    case (mode)
                        MODE_READ:
                        begin
                            if (in_list)
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = index[ADDR_W-1:0];
                                ptr_next        = {1'b0, index};
                                single_next     = 1'b1;
                                state_next      = S_SEND;
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_EMIT;
                            end
                        end
                        MODE_WRITE:
                        begin
                            if (in_list)
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = index[ADDR_W-1:0];
                                ram_req.wr_data = value;
                                res_status_next = ST_OK;
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                            end
                            state_next = S_EMIT;
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg >= CNT_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_EMIT;
                            end
                            else if (in_list)
                            begin
                                ptr_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                            else
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = count_reg[ADDR_W-1:0];
                                ram_req.wr_data = value;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = ST_OK;
                                state_next      = S_EMIT;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (in_list)
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = index[ADDR_W-1:0];
                                state_next      = S_REM_TAKE;
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_EMIT;
                            end
                        end
                        MODE_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = '0;
                                ptr_next        = '0;
                                single_next     = 1'b0;
                                state_next      = S_SEND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = ptr_reg[ADDR_W-1:0];
                state_next      = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = rd_data;
                    out_status_next = ST_OK;
                    out_last_next   = send_last;
                    if (send_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_p1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = res_data_reg;
                    out_status_next = res_status_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_INS_RD:
            begin
                if (ptr_reg == idx_ext)
                begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = idx_reg[ADDR_W-1:0];
                    ram_req.wr_data = val_reg;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = ST_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = ptr_m1[ADDR_W-1:0];
                    state_next      = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = ptr_reg[ADDR_W-1:0];
                ram_req.wr_data = rd_data;
                ptr_next        = ptr_m1;
                state_next      = S_INS_RD;
            end
            S_REM_TAKE:
            begin
                res_data_next   = rd_data;
                res_status_next = ST_OK;
                ptr_next        = idx_ext + CNT_W'(1);
                state_next      = S_REM_RD;
            end
            S_REM_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = ptr_reg[ADDR_W-1:0];
                    state_next      = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = ptr_m1[ADDR_W-1:0];
                ram_req.wr_data = rd_data;
                ptr_next        = ptr_p1;
                state_next      = S_REM_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        single_reg     <= single_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign status    = out_status_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire
